// ===== rtl/core/md5_pkg.sv =====
// Shared types, constants and round functions for the MD5 hash engine.
// Used by md5_buf_ram, md5_core and md5_hash_engine; depends on nothing else.
package md5_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } md5_in_t;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } md5_out_t;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // How the message words of a block are formed from the buffer memory.
    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_PAD,
        BLK_PAD_LEN,
        BLK_LEN
    } md5_blk_mode_t;

    typedef struct packed {
        md5_blk_mode_t mode;
        logic [5:0]    pad_pos;
        logic [63:0]   bit_len;
    } md5_blk_t;

    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [7:0] PAD_BYTE  = 8'h80;

    localparam logic [31:0] IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word used by a round.
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] i;
        logic [3:0] g;
        i = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = i;
            2'd1:    g = 4'(i * 4'd5 + 4'd1);
            2'd2:    g = 4'(i * 4'd3 + 4'd5);
            default: g = 4'(i * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        return ROT_AMT[{rnd[5:4], rnd[1:0]}];
    endfunction

    function automatic logic [31:0] round_f(input logic [5:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (rnd[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

endpackage

// ===== rtl/core/md5_buf_ram.sv =====
// Block buffer memory: sixteen 32-bit words, byte-lane writes, registered read.
// Depends on md5_pkg for nothing but house consistency of the import.
module md5_buf_ram
    import md5_pkg::*;
(
    input  logic        aclk,
    input  logic        wr_en,
    input  logic [3:0]  wr_addr,
    input  logic [1:0]  wr_lane,
    input  logic [7:0]  wr_data,
    input  logic [3:0]  rd_addr,
    output logic [31:0] rd_data
);

    logic [31:0] mem [16];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/md5_core.sv =====
// MD5 compression unit: one round per cycle over words read from md5_buf_ram.
// Holds the chaining value; forms padding and length bytes on the read path.
// Depends on md5_pkg.
module md5_core
    import md5_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  md5_blk_t    blk,
    input  logic        reinit,
    input  logic [31:0] rd_word,
    output logic [3:0]  rd_addr,
    output logic        busy,
    output logic        done,
    output md5_out_t    digest
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_FIN
    } core_state_t;

    core_state_t state_reg;
    logic [5:0]  rnd_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] cv_reg [4];
    md5_blk_t    blk_reg;

    logic [31:0] msg_word;
    logic [31:0] sum;
    logic [31:0] b_next;

    // Word for this round: memory data, overridden by the padding byte, zero
    // fill past the message and the bit length in the last eight bytes.
    always_comb begin
        logic [5:0] ad;
        logic [7:0] bt;
        logic [3:0] g;
        g = msg_index(rnd_reg);
        msg_word = '0;
        for (int k = 0; k < 4; k++) begin
            ad = {g, 2'(k)};
            bt = rd_word[8*k +: 8];
            if (blk_reg.mode == BLK_PAD || blk_reg.mode == BLK_PAD_LEN) begin
                if (ad == blk_reg.pad_pos) begin
                    bt = PAD_BYTE;
                end else if (ad > blk_reg.pad_pos) begin
                    bt = '0;
                end
            end else if (blk_reg.mode == BLK_LEN) begin
                bt = '0;
            end
            if ((blk_reg.mode == BLK_PAD_LEN || blk_reg.mode == BLK_LEN) && ad >= LEN_POS) begin
                bt = blk_reg.bit_len[{ad[2:0], 3'b000} +: 8];
            end
            msg_word[8*k +: 8] = bt;
        end
    end

    assign sum    = a_reg + round_f(rnd_reg, b_reg, c_reg, d_reg) + ROUND_K[rnd_reg] + msg_word;
    assign b_next = b_reg + rotl32(sum, rot_amount(rnd_reg));

    // The read for the next round is issued while the current one computes.
    assign rd_addr = (state_reg == C_RUN) ? msg_index(rnd_reg + 6'd1) : 4'd0;

    assign busy = (state_reg != C_IDLE);
    assign done = (state_reg == C_FIN);
    assign digest.digest_low  = {cv_reg[1], cv_reg[0]};
    assign digest.digest_high = {cv_reg[3], cv_reg[2]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            for (int i = 0; i < 4; i++) begin
                cv_reg[i] <= IV[i];
            end
        end else begin
            unique case (state_reg)
                C_IDLE: begin
                    if (reinit) begin
                        for (int i = 0; i < 4; i++) begin
                            cv_reg[i] <= IV[i];
                        end
                    end
                    if (start) begin
                        a_reg     <= cv_reg[0];
                        b_reg     <= cv_reg[1];
                        c_reg     <= cv_reg[2];
                        d_reg     <= cv_reg[3];
                        blk_reg   <= blk;
                        rnd_reg   <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN: begin
                    a_reg   <= d_reg;
                    d_reg   <= c_reg;
                    c_reg   <= b_reg;
                    b_reg   <= b_next;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == LAST_POS) begin
                        state_reg <= C_FIN;
                    end
                end
                C_FIN: begin
                    cv_reg[0] <= cv_reg[0] + a_reg;
                    cv_reg[1] <= cv_reg[1] + b_reg;
                    cv_reg[2] <= cv_reg[2] + c_reg;
                    cv_reg[3] <= cv_reg[3] + d_reg;
                    state_reg <= C_IDLE;
                end
                default: begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/md5_hash_engine.sv =====
// MD5 hash engine top level: byte intake, padding control and digest output.
// Depends on md5_pkg, md5_buf_ram and md5_core.
// An absorb that fills a block holds s_ready low while the core compresses it: 64 rounds,
// one per cycle, then the chaining add. A finish returns its digest once the padded block,
// or both blocks when padding needs two, is compressed and the output register is free.
// aresetn (synchronous) loads the initial chaining value and clears the count; the buffer
// memory is not cleared, since only written bytes are ever used.
module md5_hash_engine
    import md5_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  md5_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output md5_out_t m_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMP,
        ST_SECOND,
        ST_DRAIN
    } top_state_t;

    top_state_t  state_reg;
    logic [60:0] count_reg;
    logic [5:0]  pos_reg;
    logic [63:0] len_reg;
    logic        second_reg;
    logic        final_reg;
    logic        m_valid_reg;
    md5_out_t    out_reg;

    logic        s_accept;
    logic [5:0]  cur_pos;
    logic        core_start;
    md5_blk_t    core_blk;
    logic        core_busy;
    logic        core_done;
    logic        core_reinit;
    logic [3:0]  rd_addr;
    logic [31:0] rd_word;
    md5_out_t    chain;
    logic        out_free;

    // Transactions are taken only while no compression runs. Because the buffer
    // is written only in ST_IDLE and read only while the core runs, reads and
    // writes never touch the same word in the same cycle: no forwarding needed.
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign cur_pos  = count_reg[5:0];
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // The digest is moved into the output register only once the previous one
    // has gone; the chaining value is reloaded in the same cycle.
    assign core_reinit = (state_reg == ST_DRAIN) && out_free;

    // Start requests to the core. A full data block starts on the absorb that
    // fills it. A finish starts the padded block: when the 0x80 byte falls in
    // the last eight bytes, the length needs a second block of its own.
    always_comb begin
        core_start       = 1'b0;
        core_blk.mode    = BLK_DATA;
        core_blk.pad_pos = cur_pos;
        core_blk.bit_len = {count_reg, 3'b000};
        if (state_reg == ST_SECOND) begin
            core_start       = 1'b1;
            core_blk.mode    = BLK_LEN;
            core_blk.pad_pos = pos_reg;
            core_blk.bit_len = len_reg;
        end else if (s_accept) begin
            if (s_data.op == OP_FINISH) begin
                core_start    = 1'b1;
                core_blk.mode = (cur_pos >= LEN_POS) ? BLK_PAD : BLK_PAD_LEN;
            end else if (cur_pos == LAST_POS) begin
                core_start = 1'b1;
            end
        end
    end

    md5_buf_ram u_ram (
        .aclk    (aclk),
        .wr_en   (s_accept && (s_data.op == OP_ABSORB)),
        .wr_addr (cur_pos[5:2]),
        .wr_lane (cur_pos[1:0]),
        .wr_data (s_data.data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    md5_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (core_start),
        .blk     (core_blk),
        .reinit  (core_reinit),
        .rd_word (rd_word),
        .rd_addr (rd_addr),
        .busy    (core_busy),
        .done    (core_done),
        .digest  (chain)
    );

    // Control sequence. The byte count is cleared as soon as a finish is taken;
    // the position and bit length it gave are kept for the second, length-only block.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            second_reg  <= 1'b0;
            final_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // A new digest takes the output register in the cycle the old one
            // leaves; otherwise valid drops once the digest is taken.
            if (core_reinit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_data.op == OP_FINISH) begin
                            pos_reg    <= cur_pos;
                            len_reg    <= {count_reg, 3'b000};
                            count_reg  <= '0;
                            final_reg  <= 1'b1;
                            second_reg <= (cur_pos >= LEN_POS);
                            state_reg  <= ST_COMP;
                        end else begin
                            count_reg <= count_reg + 61'd1;
                            if (cur_pos == LAST_POS) begin
                                final_reg  <= 1'b0;
                                second_reg <= 1'b0;
                                state_reg  <= ST_COMP;
                            end
                        end
                    end
                end
                ST_COMP: begin
                    if (core_done) begin
                        if (second_reg) begin
                            state_reg <= ST_SECOND;
                        end else if (final_reg) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_SECOND: begin
                    second_reg <= 1'b0;
                    state_reg  <= ST_COMP;
                end
                ST_DRAIN: begin
                    if (out_free) begin
                        out_reg     <= chain;
                        final_reg   <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        core_start |-> !core_busy)
        else $error("core started while a compression is running");

    a_done_in_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        core_done |-> (state_reg == ST_COMP))
        else $error("core finished a block outside the compression state");

    a_result_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (count_reg == '0) && ($past(state_reg) == ST_DRAIN))
        else $error("digest presented without a completed finish");

    a_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_data.op == OP_ABSORB) && (cur_pos == LAST_POS)) |=>
            (state_reg == ST_COMP) && core_busy)
        else $error("filled block did not start a compression");

endmodule
